// ===== rtl/core/cle_pkg.sv =====
// Package for the console line editor: widths, character constants,
// result kinds, sequencer states and the structs between top and judge unit.
// No dependencies.
package cle_pkg;

   localparam int MAX_LINE = 40;
   localparam int CHAR_W   = 8;
   localparam int LEN_W    = $clog2(MAX_LINE + 1);
   localparam int ADDR_W   = $clog2(MAX_LINE);

   localparam logic [CHAR_W-1:0] ERASE_RESET = 8'd8;
   localparam logic [CHAR_W-1:0] ENTER_RESET = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_C      = 8'h63;
   localparam logic [CHAR_W-1:0] CHAR_L      = 8'h6c;
   localparam logic [CHAR_W-1:0] CHAR_S      = 8'h73;

   localparam logic [LEN_W-1:0] CLS_LEN  = LEN_W'(3);
   localparam logic [LEN_W-1:0] LINE_MAX = LEN_W'(MAX_LINE);

   // configuration register indexes
   localparam logic CSR_ERASE_CODE = 1'b0;
   localparam logic CSR_ENTER_CODE = 1'b1;

   typedef enum logic [1:0] {
      KIND_ECHO  = 2'd0,
      KIND_OK    = 2'd1,
      KIND_ERROR = 2'd2,
      KIND_CLEAR = 2'd3
   } cle_kind_type;

   typedef enum logic {
      TOP_IDLE,
      TOP_JUDGE
   } cle_top_state_type;

   typedef enum logic {
      JDG_IDLE,
      JDG_SCAN
   } cle_jdg_state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CHAR_W-1:0] wr_data;
      logic              start;
      logic [LEN_W-1:0]  length;
   } cle_judge_req_type;

   typedef struct packed {
      logic         done;
      cle_kind_type kind;
   } cle_judge_rsp_type;

   // expected character of "cls" at a given position
   function automatic logic [CHAR_W-1:0] cls_char(input logic [1:0] pos);
      logic [CHAR_W-1:0] ch;
      case (pos)
         2'd0:    ch = CHAR_C;
         2'd1:    ch = CHAR_L;
         default: ch = CHAR_S;
      endcase
      return ch;
   endfunction

endpackage

// ===== rtl/core/cle_judge.sv =====
// Line store and verdict scanner: holds the line characters in a memory and
// walks them one per cycle through a single compare stage. Uses cle_pkg.
module cle_judge
   import cle_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cle_judge_req_type ctl,
   output cle_judge_rsp_type stat
);

   logic [CHAR_W-1:0] mem [MAX_LINE];
   logic [CHAR_W-1:0] rd_data_ff;

   cle_jdg_state_type state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic              pend_ff, pend_in;
   logic              bad_ff, bad_in;
   logic              cls_ff, cls_in;
   logic              rd_en;
   logic              is_digit;
   logic              cls_hit;

   // shared compare stage on the byte just read
   always_comb begin
      is_digit = rd_data_ff inside {[CHAR_ZERO:CHAR_NINE]};
      cls_hit  = (pos_ff >= CLS_LEN) || (rd_data_ff == cls_char(pos_ff[1:0]));
   end

   always_comb begin
      state_in  = state_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      pend_in   = pend_ff;
      bad_in    = bad_ff;
      cls_in    = cls_ff;
      rd_en     = 1'b0;
      stat.done = 1'b0;
      stat.kind = KIND_OK;
      case (state_ff)
         JDG_IDLE: begin
            if (ctl.start) begin
               len_in   = ctl.length;
               idx_in   = '0;
               pend_in  = 1'b0;
               bad_in   = 1'b0;
               cls_in   = 1'b1;
               state_in = JDG_SCAN;
            end
         end
         JDG_SCAN: begin
            rd_en   = (idx_ff != len_ff);
            pend_in = rd_en;
            pos_in  = idx_ff;
            if (rd_en) begin
               idx_in = idx_ff + LEN_W'(1);
            end
            if (pend_ff) begin
               bad_in = bad_ff | ~is_digit;
               cls_in = cls_ff & cls_hit;
            end
            if (!rd_en && !pend_ff) begin
               stat.done = 1'b1;
               if (len_ff == CLS_LEN && cls_ff) begin
                  stat.kind = KIND_CLEAR;
               end else if (bad_ff) begin
                  stat.kind = KIND_ERROR;
               end else begin
                  stat.kind = KIND_OK;
               end
               state_in = JDG_IDLE;
            end
         end
         default: state_in = JDG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= JDG_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      len_ff <= len_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      bad_ff <= bad_in;
      cls_ff <= cls_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[idx_ff[ADDR_W-1:0]];
      end
   end

endmodule

// ===== rtl/core/console_line_editor_checker.sv =====
// Top level of the console line editor: handshakes, configuration registers,
// line length and result register. Uses cle_pkg and cle_judge.
//
// Usage:
//   The req_ channel carries one received character per transaction. The
//   rsp_ channel returns at most one result per character: an echo of the
//   character (kind echo), or a verdict when the line is ended (OK, error,
//   clear screen). Ignored characters (erase on an empty line, anything but
//   erase on a full line) give no result.
//   The csr_ channel writes the erase code (index 0) and the enter code
//   (index 1); it is always ready and should be used only while idle.
// Timing and throughput:
//   A stored character or an erase is answered in the cycle after acceptance.
//   On the enter character the judge unit reads the line memory one
//   character per cycle, and the last byte passes one compare stage
//   before the verdict.
//   One character is handled at a time; req_ready is low during a scan and
//   while a result waits in the output register.
// Reset: empties the line, loads erase code 8 and enter code 13. The line
//   memory itself is not cleared; only written entries are ever read.
// Stall: a result holds in the output register until rsp_ready is high, and
//   no new transaction is taken meanwhile.
module console_line_editor_checker
   import cle_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CHAR_W-1:0] req_char_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_result_kind,
   output logic [CHAR_W-1:0] rsp_echo_char,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [CHAR_W-1:0] csr_wdata
);

   cle_top_state_type state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CHAR_W-1:0] erase_ff, erase_in;
   logic [CHAR_W-1:0] enter_ff, enter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cle_kind_type      rsp_kind_ff, rsp_kind_in;
   logic [CHAR_W-1:0] rsp_echo_ff, rsp_echo_in;

   cle_judge_req_type jdg_req;
   cle_judge_rsp_type jdg_rsp;

   logic req_fire;

   cle_judge u_judge (
      .clock (clock),
      .reset (reset),
      .ctl   (jdg_req),
      .stat  (jdg_rsp)
   );

   assign req_ready       = (state_ff == TOP_IDLE) && !rsp_valid_ff;
   assign req_fire        = req_valid && req_ready;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_echo_char   = rsp_echo_ff;

   // configuration writes
   always_comb begin
      erase_in = erase_ff;
      enter_in = enter_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ERASE_CODE: erase_in = csr_wdata;
            CSR_ENTER_CODE: enter_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // character decode and sequencing
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_echo_in  = rsp_echo_ff;

      jdg_req.wr_en   = 1'b0;
      jdg_req.wr_addr = len_ff[ADDR_W-1:0];
      jdg_req.wr_data = req_char_in;
      jdg_req.start   = 1'b0;
      jdg_req.length  = len_ff;

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         TOP_IDLE: begin
            if (req_fire) begin
               if (req_char_in == erase_ff) begin
                  // erase wins even when it equals the enter code
                  if (len_ff != '0) begin
                     len_in       = len_ff - LEN_W'(1);
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_ECHO;
                     rsp_echo_in  = req_char_in;
                  end
               end else if (len_ff >= LINE_MAX) begin
                  // full line: ignore everything but erase
               end else if (req_char_in == enter_ff) begin
                  jdg_req.start = 1'b1;
                  state_in      = TOP_JUDGE;
               end else begin
                  jdg_req.wr_en = 1'b1;
                  len_in        = len_ff + LEN_W'(1);
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_ECHO;
                  rsp_echo_in   = req_char_in;
               end
            end
         end
         TOP_JUDGE: begin
            // hold until the scan reports, then empty the line
            if (jdg_rsp.done) begin
               len_in       = '0;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = jdg_rsp.kind;
               rsp_echo_in  = '0;
               state_in     = TOP_IDLE;
            end
         end
         default: state_in = TOP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         len_ff       <= '0;
         erase_ff     <= ERASE_RESET;
         enter_ff     <= ENTER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         erase_ff     <= erase_in;
         enter_ff     <= enter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_echo_ff <= rsp_echo_in;
   end

endmodule

// ===== bench/line_result_checker.sv =====
// Watching checker for the console line editor: follows the req_, rsp_ and
// csr_ channels, keeps its own copy of the line and the codes, and compares.
// Depends on cle_pkg.
module line_result_checker
   import cle_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [CHAR_W-1:0] req_char_in,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [1:0]        rsp_result_kind,
   input  logic [CHAR_W-1:0] rsp_echo_char,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic              csr_index,
   input  logic [CHAR_W-1:0] csr_wdata,
   output int                fail_count,
   output int                due_count,
   output int                checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      cle_kind_type      kind;
      logic [CHAR_W-1:0] echo;
   } line_result_type;

   line_result_type   results_due[$];
   logic [CHAR_W-1:0] line_copy [MAX_LINE];
   logic [LEN_W-1:0]  line_len   = '0;
   logic [CHAR_W-1:0] erase_code = ERASE_RESET;
   logic [CHAR_W-1:0] enter_code = ENTER_RESET;
   int                mismatches = 0;
   int                checked    = 0;

   always @(posedge clock) begin : track
      line_result_type got;
      line_result_type want;
      line_result_type fresh;
      logic            emit;
      logic            all_digits;
      if (reset) begin
         results_due.delete();
         line_len   = '0;
         erase_code = ERASE_RESET;
         enter_code = ENTER_RESET;
      end else begin
         // retire the oldest expectation first: a result never belongs to
         // the character accepted at the same edge
         if (rsp_valid && rsp_ready) begin
            got.kind = cle_kind_type'(rsp_result_kind);
            got.echo = rsp_echo_char;
            checked++;
            if (results_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("checker: result %0d unexpected: kind %0d char %02h",
                           checked, got.kind, got.echo);
            end else begin
               want = results_due.pop_front();
               if (got.kind !== want.kind || got.echo !== want.echo) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("checker: result %0d: expected kind %0d char %02h,",
                            checked, want.kind, want.echo);
                     $display(" got kind %0d char %02h", got.kind, got.echo);
                  end
               end
            end
         end

         if (req_valid && req_ready) begin
            emit       = 1'b1;
            fresh.kind = KIND_ECHO;
            fresh.echo = req_char_in;
            if (req_char_in == erase_code) begin
               // erase wins over enter when both codes are equal
               if (line_len == '0)
                  emit = 1'b0;
               else
                  line_len--;
            end else if (line_len >= LINE_MAX) begin
               emit = 1'b0;
            end else if (req_char_in == enter_code) begin
               fresh.echo = '0;
               if (line_len == CLS_LEN && line_copy[0] == CHAR_C &&
                   line_copy[1] == CHAR_L && line_copy[2] == CHAR_S) begin
                  fresh.kind = KIND_CLEAR;
               end else begin
                  all_digits = 1'b1;
                  for (int i = 0; i < MAX_LINE; i++)
                     if (i < line_len &&
                         (line_copy[i] < CHAR_ZERO || line_copy[i] > CHAR_NINE))
                        all_digits = 1'b0;
                  fresh.kind = all_digits ? KIND_OK : KIND_ERROR;
               end
               line_len = '0;
            end else begin
               line_copy[line_len] = req_char_in;
               line_len++;
            end
            if (emit)
               results_due.push_back(fresh);
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ERASE_CODE: erase_code = csr_wdata;
               CSR_ENTER_CODE: enter_code = csr_wdata;
               default: ;
            endcase
         end
      end
      fail_count    <= mismatches;
      due_count     <= results_due.size();
      checked_count <= checked;
   end

endmodule

// ===== bench/testbench.sv =====
// Top of the console line editor bench: clock, reset, character stimulus,
// code settings and the verdict. Depends on cle_pkg, line_result_checker
// and the console_line_editor_checker RTL.
module testbench
   import cle_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEMS_TOTAL   = 1750;
   localparam int PHASES        = 6;
   localparam int SETTLE_CYCLES = MAX_LINE + 10;   // longest enter scan, with margin
   localparam int LONG_HOLD     = 400;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int RUN_LIMIT_NS  = 8_000_000;

   localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2f;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3a;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   logic [CHAR_W-1:0] req_char_in = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   logic [1:0]        rsp_result_kind;
   logic [CHAR_W-1:0] rsp_echo_char;
   logic              csr_valid   = 1'b0;
   logic              csr_ready;
   logic              csr_index   = CSR_ERASE_CODE;
   logic [CHAR_W-1:0] csr_wdata   = '0;

   int fail_count;
   int due_count;
   int checked_count;

   // codes currently loaded, so that lines can be built and ended
   logic [CHAR_W-1:0] cur_erase = ERASE_RESET;
   logic [CHAR_W-1:0] cur_enter = ENTER_RESET;

   int chars_sent    = 0;
   int lines_sent    = 0;
   int src_idle_pct  = 0;
   int sink_idle_pct = 0;
   bit calm          = 1'b0;   // last part of the run: no idling on either side
   bit sink_hold     = 1'b0;   // raised by the stimulus, dropped by the sink

   console_line_editor_checker DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_echo_char   (rsp_echo_char),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   line_result_checker line_watch (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_echo_char   (rsp_echo_char),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .due_count       (due_count),
      .checked_count   (checked_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one character and hold it until the editor takes the transaction.
   // A gap, when drawn, lowers valid first so it never waits on ready.
   task automatic send_char(input logic [CHAR_W-1:0] ch);
      int gap;
      if (!calm && $urandom_range(1, 100) <= src_idle_pct) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 10);
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= ch;
      do @(posedge clock); while (!req_ready);
      chars_sent++;
   endtask

   // Drop valid and wait until every predicted result has been seen. The
   // first edge lets the checker's count catch up with the last transaction.
   task automatic wait_drained(output bit drained);
      int n;
      req_valid <= 1'b0;
      n = 0;
      @(posedge clock);
      while (due_count != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      drained = (due_count == 0);
   endtask

   // Load both codes while the editor is idle. An ignored character leaves
   // nothing to wait for, so let a full scan's worth of cycles pass as well.
   // Valid stays high across the two writes.
   task automatic set_codes(input logic [CHAR_W-1:0] erase_ch,
                            input logic [CHAR_W-1:0] enter_ch);
      bit drained;
      wait_drained(drained);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_ERASE_CODE;
      csr_wdata <= erase_ch;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_ENTER_CODE;
      csr_wdata <= enter_ch;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_erase = erase_ch;
      cur_enter = enter_ch;
   endtask

   // Mostly digits, so that OK verdicts are common; otherwise any byte.
   function automatic logic [CHAR_W-1:0] line_char();
      if ($urandom_range(0, 9) < 7)
         return CHAR_W'(CHAR_ZERO + $urandom_range(0, 9));
      return CHAR_W'($urandom());
   endfunction

   // One line: mostly short well-formed lines ended by enter, with the odd
   // erase, "cls" attempts, overfilled lines and bursts of noise.
   task automatic send_line();
      int shape;
      int len;
      shape = $urandom_range(0, 15);
      case (shape)
         0: begin
            repeat ($urandom_range(1, 4)) send_char(CHAR_W'($urandom()));
         end
         1: begin
            // run past the end: the surplus is dropped, and the first enter too when
            // no erase came before it; the line is then erased and closed by enter
            len = MAX_LINE + $urandom_range(0, 3);
            repeat (len) send_char(line_char());
            repeat ($urandom_range(0, 2)) send_char(cur_erase);
            send_char(cur_enter);
            send_char(cur_erase);
            send_char(cur_enter);
         end
         2, 3: begin
            send_char(CHAR_C);
            send_char(CHAR_L);
            if ($urandom_range(0, 1) == 0) begin
               send_char(CHAR_X);
               send_char(cur_erase);
            end
            send_char(CHAR_S);
            if ($urandom_range(0, 3) == 0)
               send_char(line_char());
            send_char(cur_enter);
         end
         default: begin
            len = $urandom_range(0, 6);
            repeat (len) begin
               send_char(line_char());
               if ($urandom_range(0, 7) == 0)
                  send_char(cur_erase);
            end
            send_char(cur_enter);
         end
      endcase
      lines_sent++;
   endtask

   // Receiver pacing. Each pass assigns ready once, at the edge it starts on.
   // Stretches of 20 to 200 passes pick no, light or heavy idling; a long
   // hold-off, when asked for, is counted out here while the sender goes on.
   initial begin : sink_pacing
      int stretch;
      stretch = 0;
      forever begin
         @(posedge clock);
         if (stretch == 0) begin
            stretch = $urandom_range(20, 200);
            case ($urandom_range(0, 2))
               0:       sink_idle_pct = 0;
               1:       sink_idle_pct = 10;
               default: sink_idle_pct = 40;
            endcase
         end
         stretch--;
         if (sink_hold) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            sink_hold = 1'b0;
         end else if (!calm && $urandom_range(1, 100) <= sink_idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10) - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [CHAR_W-1:0] directed[$];
      logic [CHAR_W-1:0] same_code;
      int                phase_target;
      bit                drained;
      bit                held;
      bit                paused;
      held   = 1'b0;
      paused = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed lines with the reset codes: enter on an empty line, erase
      // on an empty line, the clear command plain and after an erase, the
      // clear command with a surplus character, the digit bounds, the
      // neighbours of the digits, and the extreme byte values.
      directed = '{ENTER_RESET,
                   ERASE_RESET,
                   CHAR_C, CHAR_L, CHAR_S, ENTER_RESET,
                   CHAR_C, CHAR_L, CHAR_X, ERASE_RESET, CHAR_S, ENTER_RESET,
                   CHAR_C, CHAR_L, CHAR_S, CHAR_ZERO, ENTER_RESET,
                   CHAR_ZERO, CHAR_NINE, ENTER_RESET,
                   CHAR_SLASH, CHAR_COLON, ENTER_RESET,
                   8'h00, 8'hff, ENTER_RESET};
      foreach (directed[i])
         send_char(directed[i]);

      // Random phases, each under its own pair of codes: reset values,
      // both extremes each way round, equal codes, random codes, and back.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1: set_codes(8'h00, 8'hff);
            2: set_codes(8'hff, 8'h00);
            3: begin
               same_code = CHAR_W'($urandom());
               set_codes(same_code, same_code);
            end
            4: set_codes(CHAR_W'($urandom()), CHAR_W'($urandom()));
            5: begin
               set_codes(ERASE_RESET, ENTER_RESET);
               calm = 1'b1;
            end
            default: ;
         endcase
         phase_target = chars_sent + ITEMS_TOTAL / PHASES;
         while (chars_sent < phase_target) begin
            if ($urandom_range(0, 9) == 0) begin
               case ($urandom_range(0, 2))
                  0:       src_idle_pct = 0;
                  1:       src_idle_pct = 15;
                  default: src_idle_pct = 50;
               endcase
            end
            // long receiver hold-off while characters keep coming
            if (phase == 1 && !held && chars_sent > phase_target - 150) begin
               sink_hold = 1'b1;
               held      = 1'b1;
            end
            // sender pause until the editor has answered everything
            if (phase == 2 && !paused && chars_sent > phase_target - 150) begin
               wait_drained(drained);
               paused = 1'b1;
            end
            send_line();
         end
      end

      // Drain, then allow one more scan's worth of cycles for stragglers.
      wait_drained(drained);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_count != 0)
         $display("testbench: %0d predicted results never arrived", due_count);
      $display("summary: %0d characters in %0d lines plus directed items, %0d code settings",
               chars_sent, lines_sent, PHASES);
      $display("summary: %0d results compared, %0d mismatches", checked_count, fail_count);
      if (drained && fail_count == 0 && due_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/cle_pkg.sv
rtl/core/cle_judge.sv
rtl/core/console_line_editor_checker.sv
bench/line_result_checker.sv
bench/testbench.sv
